// ===== rtl/bslp_pkg.sv =====
`default_nettype none

package bslp_pkg;

  localparam int DEF_NUM_BUTTONS = 3;
  localparam int DEF_COUNT_WIDTH = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CONFIRM_W  = 8;
  localparam int THRESH_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_CONFIRM   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_MIN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG      = 2'd2;

  localparam logic [CONFIRM_W-1:0] RST_CONFIRM   = 8'd3;
  localparam logic [THRESH_W-1:0]  RST_SHORT_MIN = 16'd3;
  localparam logic [THRESH_W-1:0]  RST_LONG      = 16'd80;

  typedef struct packed {
    logic [CONFIRM_W-1:0] confirm_ticks;
    logic [THRESH_W-1:0]  short_min_ticks;
    logic [THRESH_W-1:0]  long_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/button_short_long_press_classifier.sv =====
`default_nettype none

// Debounces NUM_BUTTONS active-low buttons and reports short and long presses. Each input
// request is one sample tick; the block accepts one tick per clock cycle while its two-entry
// event queue has room, and every tick updates all buttons at once. The events a tick causes
// leave in button order, one per cycle through the output register while the receiver is
// ready, the last one of the tick marked with tlast; a tick with none produces no output
// request. The user must write the registers through the cfg port only while the block is
// idle; the block itself does not enforce this.
module button_short_long_press_classifier #(
  parameter int NUM_BUTTONS = bslp_pkg::DEF_NUM_BUTTONS,
  parameter int COUNT_WIDTH = bslp_pkg::DEF_COUNT_WIDTH,
  localparam int ID_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
  localparam int IN_W  = ((NUM_BUTTONS + 7) / 8) * 8,
  localparam int OUT_W = ((ID_W + 1 + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [IN_W-1:0]                 in_tdata,   // raw_levels
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [OUT_W-1:0]                     out_tdata,  // button_id, long_flag
  output logic                                 out_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [bslp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bslp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bslp_pkg::cfg_t cfg_r, cfg_nxt;

  logic                   q_push, q_pop, q_full, q_valid;
  logic [NUM_BUTTONS-1:0] push_fire, push_long, q_fire, q_long;
  logic [ID_W-1:0]        out_id;
  logic                   out_long;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        bslp_pkg::CFG_CONFIRM:   cfg_nxt.confirm_ticks   = cfg_wdata[bslp_pkg::CONFIRM_W-1:0];
        bslp_pkg::CFG_SHORT_MIN: cfg_nxt.short_min_ticks = cfg_wdata[bslp_pkg::THRESH_W-1:0];
        bslp_pkg::CFG_LONG:      cfg_nxt.long_ticks      = cfg_wdata[bslp_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_ticks   <= bslp_pkg::RST_CONFIRM;
      cfg_r.short_min_ticks <= bslp_pkg::RST_SHORT_MIN;
      cfg_r.long_ticks      <= bslp_pkg::RST_LONG;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bslp_front #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_levels (in_tdata[NUM_BUTTONS-1:0]),
    .in_ready  (in_tready),
    .q_full    (q_full),
    .push      (q_push),
    .push_fire (push_fire),
    .push_long (push_long)
  );

  bslp_queue #(
    .WIDTH (2 * NUM_BUTTONS),
    .DEPTH (bslp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   ({push_long, push_fire}),
    .pop       (q_pop),
    .rd_data   ({q_long, q_fire}),
    .full      (q_full),
    .not_empty (q_valid)
  );

  bslp_back #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .ID_W        (ID_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_fire    (q_fire),
    .q_long    (q_long),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_id    (out_id),
    .out_long  (out_long),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_W'({out_long, out_id});

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("event pushed into a full queue");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("events of one tick were split by a gap");

  a_id_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_id < ID_W'(NUM_BUTTONS)) || (NUM_BUTTONS == (1 << ID_W)))
    else $error("button id out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/bslp_front.sv =====
`default_nettype none

module bslp_front #(
  parameter int NUM_BUTTONS = bslp_pkg::DEF_NUM_BUTTONS,
  parameter int COUNT_WIDTH = bslp_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bslp_pkg::cfg_t         cfg,
  input  wire logic                   in_valid,
  input  wire logic [NUM_BUTTONS-1:0] in_levels,
  output logic                        in_ready,
  input  wire logic                   q_full,
  output logic                        push,
  output logic [NUM_BUTTONS-1:0]      push_fire,
  output logic [NUM_BUTTONS-1:0]      push_long
);

  localparam int CMP_W = (COUNT_WIDTH > bslp_pkg::THRESH_W) ? COUNT_WIDTH : bslp_pkg::THRESH_W;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_CONFIRM = 2'd1;
  localparam logic [1:0] PH_DOWN    = 2'd2;

  logic                        accept;
  wire logic [NUM_BUTTONS-1:0] fire;
  wire logic [NUM_BUTTONS-1:0] kind;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (|fire);
  assign push_fire = fire;
  assign push_long = kind;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic [1:0]             phase_r, phase_nxt;
    logic [COUNT_WIDTH-1:0] hold_r, hold_nxt, hold_inc;
    logic                   sent_r, sent_nxt;
    logic [CMP_W-1:0]       hold_ext;
    logic                   pressed;
    logic                   fire_l, kind_l;

    assign pressed  = !in_levels[b];
    assign hold_inc = (&hold_r) ? hold_r : hold_r + 1'b1;
    assign hold_ext = CMP_W'(hold_inc);
    assign fire[b]  = fire_l;
    assign kind[b]  = kind_l;

    always_comb begin
      phase_nxt = phase_r;
      hold_nxt  = hold_r;
      sent_nxt  = sent_r;
      fire_l    = 1'b0;
      kind_l    = 1'b0;
      if (accept) begin
        unique case (phase_r)
          PH_CONFIRM: begin
            hold_nxt = hold_inc;
            if (hold_ext >= CMP_W'(cfg.confirm_ticks)) begin
              if (pressed) begin
                phase_nxt = PH_DOWN;
              end else begin
                phase_nxt = PH_IDLE;
                hold_nxt  = '0;
              end
            end
          end
          PH_DOWN: begin
            hold_nxt = hold_inc;
            if (pressed) begin
              if (!sent_r && (hold_ext >= CMP_W'(cfg.long_ticks))) begin
                fire_l   = 1'b1;
                kind_l   = 1'b1;
                sent_nxt = 1'b1;
              end
            end else begin
              if (!sent_r && (hold_ext >= CMP_W'(cfg.short_min_ticks))) begin
                fire_l = 1'b1;
              end
              phase_nxt = PH_IDLE;
              sent_nxt  = 1'b0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            if (pressed) begin
              phase_nxt = PH_CONFIRM;
              hold_nxt  = '0;
              sent_nxt  = 1'b0;
            end
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        phase_r <= PH_IDLE;
        hold_r  <= '0;
        sent_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        hold_r  <= hold_nxt;
        sent_r  <= sent_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bslp_queue.sv =====
`default_nettype none

module bslp_queue #(
  parameter int WIDTH = 2,
  parameter int DEPTH = bslp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bslp_back.sv =====
`default_nettype none

module bslp_back #(
  parameter int NUM_BUTTONS = bslp_pkg::DEF_NUM_BUTTONS,
  parameter int ID_W        = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire logic [NUM_BUTTONS-1:0] q_fire,
  input  wire logic [NUM_BUTTONS-1:0] q_long,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ID_W-1:0]             out_id,
  output logic                        out_long,
  output logic                        out_last
);

  logic [NUM_BUTTONS-1:0] cur_fire_r, cur_fire_nxt;
  logic [NUM_BUTTONS-1:0] cur_long_r, cur_long_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]        out_id_r, sel_idx;
  logic                   out_long_r, out_last_r;
  logic [NUM_BUTTONS-1:0] sel_hot, rem;
  logic                   out_free, emit;

  always_comb begin
    sel_idx = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (cur_fire_r[i]) begin
        sel_idx = ID_W'(i);
      end
    end
  end

  assign sel_hot  = cur_fire_r & (~cur_fire_r + 1'b1);
  assign out_free = !out_valid_r || out_ready;
  assign emit     = out_free && (|cur_fire_r);
  assign rem      = emit ? (cur_fire_r & ~sel_hot) : cur_fire_r;
  assign q_pop    = q_valid && (rem == '0);

  always_comb begin
    cur_fire_nxt  = rem;
    cur_long_nxt  = cur_long_r;
    if (q_pop) begin
      cur_fire_nxt = q_fire;
      cur_long_nxt = q_long;
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_fire_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_fire_r  <= cur_fire_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_long_r <= cur_long_nxt;
    if (emit) begin
      out_id_r   <= sel_idx;
      out_long_r <= |(cur_long_r & sel_hot);
      out_last_r <= ((cur_fire_r & ~sel_hot) == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_id    = out_id_r;
  assign out_long  = out_long_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== bench/button_short_long_press_classifier_tb.sv =====
`timescale 1ns / 1ps

module button_short_long_press_classifier_tb;

  localparam int NUM_BTN     = bslp_pkg::DEF_NUM_BUTTONS;
  localparam int SETTLE      = 12;
  localparam int HOLDOFF     = 200;
  localparam int STUCK_LIMIT = 5000;

  typedef enum logic [1:0] {
    BTN_IDLE,
    BTN_CONFIRM,
    BTN_DOWN
  } btn_phase_e;

  typedef struct packed {
    logic [1:0] button_id;
    logic       long_flag;
    logic       last_event;
  } press_event_t;

  class press_scoreboard;
    logic [7:0]   confirm_ticks;
    logic [15:0]  short_min;
    logic [15:0]  long_thr;
    btn_phase_e   phase_of [NUM_BTN];
    logic [15:0]  hold [NUM_BTN];
    logic         long_sent [NUM_BTN];
    press_event_t pending [$];
    int unsigned  errors;
    int unsigned  events_seen;
    int unsigned  ticks_seen;
    int unsigned  settings;

    function new();
      confirm_ticks = bslp_pkg::RST_CONFIRM;
      short_min     = bslp_pkg::RST_SHORT_MIN;
      long_thr      = bslp_pkg::RST_LONG;
      for (int b = 0; b < NUM_BTN; b++) begin
        phase_of[b]  = BTN_IDLE;
        hold[b]      = '0;
        long_sent[b] = 1'b0;
      end
      errors      = 0;
      events_seen = 0;
      ticks_seen  = 0;
      settings    = 1;
    endfunction

    function void set_reg(logic [1:0] addr, logic [15:0] value);
      case (addr)
        bslp_pkg::CFG_CONFIRM:   confirm_ticks = value[7:0];
        bslp_pkg::CFG_SHORT_MIN: short_min = value;
        bslp_pkg::CFG_LONG:      long_thr = value;
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task note_tick(logic [2:0] levels);
      press_event_t tick_events [$];
      press_event_t ev;
      logic pressed;
      logic fire;
      logic is_long;
      ticks_seen++;
      for (int b = 0; b < NUM_BTN; b++) begin
        pressed = !levels[b];
        fire    = 1'b0;
        is_long = 1'b0;
        case (phase_of[b])
          BTN_CONFIRM: begin
            if (hold[b] != 16'hFFFF) hold[b]++;
            if (hold[b] >= {8'd0, confirm_ticks}) begin
              if (pressed) begin
                phase_of[b] = BTN_DOWN;
              end else begin
                phase_of[b] = BTN_IDLE;
                hold[b]     = '0;
              end
            end
          end
          BTN_DOWN: begin
            if (hold[b] != 16'hFFFF) hold[b]++;
            if (pressed) begin
              if (!long_sent[b] && hold[b] >= long_thr) begin
                fire         = 1'b1;
                is_long      = 1'b1;
                long_sent[b] = 1'b1;
              end
            end else begin
              if (!long_sent[b] && hold[b] >= short_min) fire = 1'b1;
              phase_of[b]  = BTN_IDLE;
              long_sent[b] = 1'b0;
            end
          end
          default: begin
            phase_of[b] = BTN_IDLE;
            if (pressed) begin
              phase_of[b]  = BTN_CONFIRM;
              hold[b]      = '0;
              long_sent[b] = 1'b0;
            end
          end
        endcase
        if (fire) begin
          ev.button_id  = 2'(b);
          ev.long_flag  = is_long;
          ev.last_event = 1'b0;
          tick_events.push_back(ev);
        end
      end
      if (tick_events.size() > 0) tick_events[tick_events.size() - 1].last_event = 1'b1;
      foreach (tick_events[i]) pending.push_back(tick_events[i]);
    endtask

    task check_event(logic [1:0] button_id, logic long_flag, logic last_event);
      press_event_t want;
      events_seen++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("event button %0d long %0b with nothing pending",
                                  button_id, long_flag));
      end else begin
        want = pending.pop_front();
        if (button_id !== want.button_id)
          report_mismatch($sformatf("button_id %0d, expected %0d", button_id, want.button_id));
        if (long_flag !== want.long_flag)
          report_mismatch($sformatf("long flag %0b, expected %0b on button %0d",
                                    long_flag, want.long_flag, want.button_id));
        if (last_event !== want.last_event)
          report_mismatch($sformatf("tlast %0b, expected %0b on button %0d",
                                    last_event, want.last_event, want.button_id));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'hFF;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [bslp_pkg::CFG_ADDR_W-1:0] cfg_addr = bslp_pkg::CFG_CONFIRM;
  logic [bslp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  press_scoreboard sb;
  bit calm = 1'b0;
  bit holdoff_go = 1'b0;
  int holdoff_left = 0;
  int stall_left = 0;
  int stuck_cycles = 0;

  button_short_long_press_classifier u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_event(out_tdata[1:0], out_tdata[2], out_tlast);
      if (in_tvalid && in_tready) sb.note_tick(in_tdata[2:0]);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("no progress for %0d cycles", STUCK_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (holdoff_go) begin
      holdoff_left = HOLDOFF;
      holdoff_go   = 1'b0;
    end
    if (holdoff_left > 0) begin
      out_tready <= 1'b0;
      holdoff_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_tick(input logic [2:0] levels);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, levels};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(addr, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_thresholds(input logic [7:0] confirm, input logic [15:0] short_min,
                                    input logic [15:0] long_thr);
    wait_idle();
    write_reg(bslp_pkg::CFG_CONFIRM, {8'd0, confirm});
    write_reg(bslp_pkg::CFG_SHORT_MIN, short_min);
    write_reg(bslp_pkg::CFG_LONG, long_thr);
    sb.settings++;
  endtask

  // Each button toggles between pressed and released runs of random length, mostly long
  // enough to pass the confirm wait, with occasional single-tick glitches mixed in.
  task automatic random_presses(input int ticks);
    logic [2:0] levels;
    int run_left [NUM_BTN];
    int span;
    levels = 3'b111;
    for (int b = 0; b < NUM_BTN; b++) run_left[b] = $urandom_range(0, 6);
    span = int'(sb.confirm_ticks) + int'(sb.long_thr) + 4;
    repeat (ticks) begin
      for (int b = 0; b < NUM_BTN; b++) begin
        if (run_left[b] == 0) begin
          levels[b] = ~levels[b];
          if ($urandom_range(0, 2) == 0) run_left[b] = $urandom_range(1, sb.confirm_ticks + 2);
          else run_left[b] = $urandom_range(1, span);
        end
        run_left[b]--;
      end
      if ($urandom_range(0, 9) == 0) send_tick(levels ^ 3'($urandom_range(1, 7)));
      else send_tick(levels);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: glitch during the confirm wait, release at the re-sample, short press.
    send_tick(3'b111);
    send_tick(3'b100);
    send_tick(3'b111);
    send_tick(3'b110);
    send_tick(3'b110);
    send_tick(3'b111);

    // A press far below the short minimum gives nothing.
    program_thresholds(8'd1, 16'hFFFF, 16'hFFFF);
    send_tick(3'b110);
    send_tick(3'b110);
    send_tick(3'b110);
    send_tick(3'b111);

    // Zero confirm and zero thresholds: short on the first release, long on all three at once.
    program_thresholds(8'd0, 16'd0, 16'd0);
    send_tick(3'b101);
    send_tick(3'b101);
    send_tick(3'b111);
    send_tick(3'b000);
    send_tick(3'b000);
    send_tick(3'b000);
    send_tick(3'b111);

    // Longest confirm and thresholds: the presses never leave the confirm wait.
    program_thresholds(8'd255, 16'hFFFF, 16'hFFFF);
    repeat (6) send_tick(3'b000);
    send_tick(3'b111);

    // Receiver holds off while long presses pile up on every button.
    program_thresholds(8'd1, 16'd0, 16'd1);
    @(posedge clk);
    holdoff_go = 1'b1;
    repeat (10) begin
      send_tick(3'b000);
      send_tick(3'b000);
      send_tick(3'b000);
      send_tick(3'b111);
    end

    program_thresholds(8'd1, 16'd0, 16'd1);
    random_presses(16);
    for (int p = 0; p < 3; p++) begin
      program_thresholds(8'($urandom_range(1, 4)), 16'($urandom_range(0, 6)),
                         16'($urandom_range(1, 24)));
      random_presses(16);
    end

    program_thresholds(8'($urandom_range(1, 3)), 16'($urandom_range(0, 4)),
                       16'($urandom_range(2, 12)));
    @(posedge clk);
    calm = 1'b1;
    random_presses(16);

    wait_idle();
    $display("Ran %0d sample ticks under %0d threshold settings, %0d press events checked.",
             sb.ticks_seen, sb.settings, sb.events_seen);
    $display("Included zero and maximal thresholds, glitches and a long output stall.");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== button_short_long_press_classifier.f =====
rtl/bslp_pkg.sv
rtl/bslp_front.sv
rtl/bslp_queue.sv
rtl/bslp_back.sv
rtl/button_short_long_press_classifier.sv
bench/button_short_long_press_classifier_tb.sv
